// ===== src/hav_pkg.sv =====
// Package for the haversine distance pipeline: fixed-point constants, the
// CORDIC angle table and helper functions. No dependencies.
`default_nettype none
package hav_pkg;
   localparam int unsigned LatW = 31;
   localparam int unsigned LonW = 32;
   localparam int unsigned RadW = 30;
   localparam int unsigned DistW = 31;
   localparam int unsigned CW = 34;
   localparam int unsigned TabN = 32;
   localparam logic signed [LatW-1:0] LatLimit = 31'sd900000000;
   localparam logic signed [LonW-1:0] LonLimit = 32'sd1800000000;
   localparam logic [CW-1:0] OneQ30 = 34'd1073741824;
   localparam logic [CW-1:0] GainQ30 = 34'd652032874;
   localparam logic [30:0] PiQ29 = 31'd1686629713;
   localparam logic [31:0] RecipM = 32'd2562047788;
   localparam logic [54:0] HalfK = 55'd3515625;
   localparam logic [54:0] TwoK = 55'd7031250;
   localparam logic [54:0] FourK = 55'd14062500;
   localparam logic [RadW-1:0] RadiusReset = 30'd637279548;

   typedef logic signed [CW+1:0] cval_type;

   function automatic logic [CW-1:0] atan_angle(input int unsigned i);
      logic [CW-1:0] t [TabN];
      t = '{34'd536870912, 34'd316933406, 34'd167458907, 34'd85004756,
            34'd42667331, 34'd21354465, 34'd10679838, 34'd5340245,
            34'd2670163, 34'd1335087, 34'd667544, 34'd333772, 34'd166886,
            34'd83443, 34'd41722, 34'd20861, 34'd10430, 34'd5215, 34'd2608,
            34'd1304, 34'd652, 34'd326, 34'd163, 34'd81, 34'd41, 34'd20,
            34'd10, 34'd5, 34'd3, 34'd1, 34'd1, 34'd0};
      return (i < TabN) ? t[i] : '0;
   endfunction

   function automatic cval_type clamp_q30(input cval_type v);
      if (v < 0) return '0;
      if (v > $signed({2'b00, OneQ30})) return $signed({2'b00, OneQ30});
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== src/haversine_distance.sv =====
// Haversine great-circle distance: deep pipeline with unrolled CORDIC
// sine/cosine, squaring and products, digit-serial roots and atan2 CORDIC.
// Depends on hav_pkg.
//
// Usage: drive req_* fields and pulse start while busy is low; busy is
// held low at all times, so one point pair is taken every cycle. Each
// word moves through a fixed pipeline: the distance leaves on rsp_distance_cm
// with rsp_valid high for one cycle. The length is set by the two CORDIC
// chains (one stage per iteration), the two 32-digit square roots (two
// digits per stage), the three angle scaling stages and the multiplier
// stages around them. Throughput is one word per cycle.
// The receiver cannot stall, so nothing is held back. Reset empties the
// pipeline's valid bits and loads the radius register with its default;
// csr_we writes the radius at any edge, and it is used by every word that
// reaches the output multiplier afterwards, so write it while nothing is
// in flight.
`default_nettype none
module haversine_distance #(
   parameter int unsigned CORDIC_STAGES = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  signed [hav_pkg::LatW-1:0] req_first_latitude,
   input  wire  signed [hav_pkg::LonW-1:0] req_first_longitude,
   input  wire  signed [hav_pkg::LatW-1:0] req_second_latitude,
   input  wire  signed [hav_pkg::LonW-1:0] req_second_longitude,
   input  wire                          csr_we,
   input  wire  [hav_pkg::RadW-1:0]     csr_wdata,
   output logic                         rsp_valid,
   output logic [hav_pkg::DistW-1:0]    rsp_distance_cm
);
   import hav_pkg::*;

   localparam int unsigned N = CORDIC_STAGES;
   localparam int unsigned SqN = 16;

   logic [RadW-1:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end
   assign busy = 1'b0;

   // Stage A: clamp and differences.
   logic a_v_ff, a_zero_ff;
   logic [31:0] a_dlat_ff, a_dlon_ff;
   logic [30:0] a_l1_ff, a_l2_ff;
   logic signed [LatW-1:0] cl1, cl2;
   logic signed [LonW-1:0] co1, co2;
   always_comb begin
      cl1 = req_first_latitude > LatLimit ? LatLimit :
            (req_first_latitude < -LatLimit ? -LatLimit : req_first_latitude);
      cl2 = req_second_latitude > LatLimit ? LatLimit :
            (req_second_latitude < -LatLimit ? -LatLimit : req_second_latitude);
      co1 = req_first_longitude > LonLimit ? LonLimit :
            (req_first_longitude < -LonLimit ? -LonLimit : req_first_longitude);
      co2 = req_second_longitude > LonLimit ? LonLimit :
            (req_second_longitude < -LonLimit ? -LonLimit : req_second_longitude);
   end
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else a_v_ff <= start && !busy;
      a_zero_ff <= (cl1 == cl2) && (co1 == co2);
      a_dlat_ff <= (cl1 >= cl2) ? ({cl1[30], cl1} - {cl2[30], cl2})
                                : ({cl2[30], cl2} - {cl1[30], cl1});
      a_dlon_ff <= (co1 >= co2) ? 32'({co1[31], co1} - {co2[31], co2})
                                : 32'({co2[31], co2} - {co1[31], co1});
      a_l1_ff <= cl1[30] ? 31'(-cl1) : 31'(cl1);
      a_l2_ff <= cl2[30] ? 31'(-cl2) : 31'(cl2);
   end

   // Stage B: binary angles as round(e * 2^21 / 3515625), where e is a
   // difference or twice a latitude. A reciprocal product gives an estimate
   // that two remainder checks correct; half angles above 90 degrees fold.
   logic b1_v_ff, b1_zero_ff, b2_v_ff, b2_zero_ff, b_v_ff, b_zero_ff;
   logic [31:0] b_e [4];
   logic [31:0] b_q [4];
   logic [31:0] b1_e_ff [4], b1_q_ff [4], b2_q_ff [4];
   logic [54:0] b2_x_ff [4], b2_m_ff [4];
   logic [CW-1:0] b_z_ff [4];
   always_comb begin
      b_e[0] = a_dlat_ff;
      b_e[1] = a_dlon_ff;
      b_e[2] = {a_l1_ff, 1'b0};
      b_e[3] = {a_l2_ff, 1'b0};
      for (int k = 0; k < 4; k++) begin
         b_q[k] = b2_q_ff[k] + 32'(b2_x_ff[k] >= b2_m_ff[k] + TwoK)
                  + 32'(b2_x_ff[k] >= b2_m_ff[k] + FourK);
         if (b_q[k] > 32'(OneQ30)) b_q[k] = 32'd2147483648 - b_q[k];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0; b2_v_ff <= 1'b0; b_v_ff <= 1'b0;
      end else begin
         b1_v_ff <= a_v_ff; b2_v_ff <= b1_v_ff; b_v_ff <= b2_v_ff;
      end
      b1_zero_ff <= a_zero_ff;
      b2_zero_ff <= b1_zero_ff;
      b_zero_ff <= b2_zero_ff;
      for (int k = 0; k < 4; k++) begin
         b1_e_ff[k] <= b_e[k];
         b1_q_ff[k] <= 32'((64'(b_e[k]) * 64'(RecipM)) >> 32);
         b2_q_ff[k] <= b1_q_ff[k];
         b2_x_ff[k] <= {1'b0, b1_e_ff[k], 22'd0} + HalfK;
         b2_m_ff[k] <= 55'(b1_q_ff[k]) * TwoK;
         b_z_ff[k] <= {2'b00, b_q[k]};
      end
   end

   // Rotation CORDIC, four lanes, one stage per iteration.
   cval_type rx_ff [N+1][4], ry_ff [N+1][4], rz_ff [N+1][4];
   logic rv_ff [N+1];
   logic rzero_ff [N+1];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rx_ff[0][k] = $signed({2'b00, GainQ30});
         ry_ff[0][k] = '0;
         rz_ff[0][k] = $signed({2'b00, b_z_ff[k]});
      end
      rv_ff[0] = b_v_ff;
      rzero_ff[0] = b_zero_ff;
   end
   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) rv_ff[i+1] <= 1'b0;
         else rv_ff[i+1] <= rv_ff[i];
         rzero_ff[i+1] <= rzero_ff[i];
         for (int k = 0; k < 4; k++) begin
            if (rz_ff[i][k] >= 0) begin
               rx_ff[i+1][k] <= rx_ff[i][k] - (ry_ff[i][k] >>> i);
               ry_ff[i+1][k] <= ry_ff[i][k] + (rx_ff[i][k] >>> i);
               rz_ff[i+1][k] <= rz_ff[i][k] - $signed({2'b00, atan_angle(i)});
            end else begin
               rx_ff[i+1][k] <= rx_ff[i][k] + (ry_ff[i][k] >>> i);
               ry_ff[i+1][k] <= ry_ff[i][k] - (rx_ff[i][k] >>> i);
               rz_ff[i+1][k] <= rz_ff[i][k] + $signed({2'b00, atan_angle(i)});
            end
         end
      end
   end

   // Products: stage P1 squares and c1*c2, P2 the cross product, P3 sum.
   logic p1_v_ff, p1_zero_ff, p2_v_ff, p2_zero_ff, p3_v_ff, p3_zero_ff;
   logic [31:0] p1_s1_ff, p1_s2_ff, p1_cc_ff, p2_s1_ff, p2_p_ff;
   logic [CW-1:0] p3_a_ff;
   logic [30:0] s1, s2, c1, c2;
   logic [31:0] asum;
   always_comb begin
      s1 = 31'(clamp_q30(ry_ff[N][0]));
      s2 = 31'(clamp_q30(ry_ff[N][1]));
      c1 = 31'(clamp_q30(rx_ff[N][2]));
      c2 = 31'(clamp_q30(rx_ff[N][3]));
      asum = p2_s1_ff + p2_p_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0; p2_v_ff <= 1'b0; p3_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= rv_ff[N]; p2_v_ff <= p1_v_ff; p3_v_ff <= p2_v_ff;
      end
      p1_zero_ff <= rzero_ff[N];
      p1_s1_ff <= 32'((62'(s1) * 62'(s1)) >> 30);
      p1_s2_ff <= 32'((62'(s2) * 62'(s2)) >> 30);
      p1_cc_ff <= 32'((62'(c1) * 62'(c2)) >> 30);
      p2_zero_ff <= p1_zero_ff;
      p2_s1_ff <= p1_s1_ff;
      p2_p_ff <= 32'((64'(p1_cc_ff) * 64'(p1_s2_ff)) >> 30);
      p3_zero_ff <= p2_zero_ff;
      p3_a_ff <= (asum > 32'(OneQ30)) ? OneQ30 : 34'(asum);
   end

   // Two square roots, two result bits per stage over the 64-bit radicand.
   logic [63:0] qv_ff [SqN+1][2], qr_ff [SqN+1][2];
   logic qvl_ff [SqN+1];
   logic qz_ff [SqN+1];
   always_comb begin
      qv_ff[0][0] = 64'(p3_a_ff) << 30;
      qv_ff[0][1] = 64'(OneQ30 - p3_a_ff) << 30;
      qr_ff[0][0] = '0;
      qr_ff[0][1] = '0;
      qvl_ff[0] = p3_v_ff;
      qz_ff[0] = p3_zero_ff;
   end
   for (genvar j = 0; j < SqN; j++) begin : g_sqrt
      localparam logic [63:0] B0 = 64'd1 << (62 - 4 * j);
      localparam logic [63:0] B1 = 64'd1 << (60 - 4 * j);
      logic [63:0] v1 [2], r1 [2];
      always_comb begin
         for (int k = 0; k < 2; k++) begin
            if (qv_ff[j][k] >= qr_ff[j][k] + B0) begin
               v1[k] = qv_ff[j][k] - (qr_ff[j][k] + B0);
               r1[k] = (qr_ff[j][k] >> 1) + B0;
            end else begin
               v1[k] = qv_ff[j][k];
               r1[k] = qr_ff[j][k] >> 1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) qvl_ff[j+1] <= 1'b0;
         else qvl_ff[j+1] <= qvl_ff[j];
         qz_ff[j+1] <= qz_ff[j];
         for (int k = 0; k < 2; k++) begin
            if (B1 != 0 && v1[k] >= r1[k] + B1) begin
               qv_ff[j+1][k] <= v1[k] - (r1[k] + B1);
               qr_ff[j+1][k] <= (r1[k] >> 1) + B1;
            end else begin
               qv_ff[j+1][k] <= v1[k];
               qr_ff[j+1][k] <= (B1 != 0) ? (r1[k] >> 1) : r1[k];
            end
         end
      end
   end

   // Vectoring CORDIC for atan2(sqrt(a), sqrt(1-a)).
   cval_type vx_ff [N+1], vy_ff [N+1], vz_ff [N+1];
   logic vv_ff [N+1];
   logic vzero_ff [N+1];
   always_comb begin
      vx_ff[0] = $signed(36'(qr_ff[SqN][1]));
      vy_ff[0] = $signed(36'(qr_ff[SqN][0]));
      vz_ff[0] = '0;
      vv_ff[0] = qvl_ff[SqN];
      vzero_ff[0] = qz_ff[SqN];
   end
   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (reset) vv_ff[i+1] <= 1'b0;
         else vv_ff[i+1] <= vv_ff[i];
         vzero_ff[i+1] <= vzero_ff[i];
         if (vy_ff[i] > 0) begin
            vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] + $signed({2'b00, atan_angle(i)});
         end else begin
            vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] - $signed({2'b00, atan_angle(i)});
         end
      end
   end

   // Scale: R*z, then the two pi products, then sum and saturate, or zero for equal points.
   logic m1_v_ff, m1_zero_ff, m2_v_ff, m2_zero_ff, o_v_ff;
   logic [60:0] m1_p_ff;
   logic [61:0] m2_hi_ff, m2_lo_ff;
   logic [DistW-1:0] o_d_ff;
   logic [62:0] dsum;
   logic [30:0] zc;
   always_comb begin
      zc = 31'(clamp_q30(vz_ff[N]));
      dsum = (63'(m2_hi_ff) + 63'(m2_lo_ff >> 30)) >> 29;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0; m2_v_ff <= 1'b0; o_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= vv_ff[N]; m2_v_ff <= m1_v_ff; o_v_ff <= m2_v_ff;
      end
      m1_zero_ff <= vzero_ff[N];
      m1_p_ff <= 61'(radius_ff) * 61'(zc);
      m2_zero_ff <= m1_zero_ff;
      m2_hi_ff <= 62'(m1_p_ff >> 30) * 62'(PiQ29);
      m2_lo_ff <= 62'(m1_p_ff[29:0]) * 62'(PiQ29);
      if (m2_zero_ff) o_d_ff <= '0;
      else if (dsum > 63'h7FFFFFFF) o_d_ff <= '1;
      else o_d_ff <= dsum[DistW-1:0];
   end

   assign rsp_valid = o_v_ff;
   assign rsp_distance_cm = o_d_ff;
endmodule
`default_nettype wire

// ===== src/haversine_distance_checker.sv =====
// Port-level checker for haversine_distance, bound to the top level.
// Depends on hav_pkg for widths.
`default_nettype none
module haversine_distance_checker #(
   parameter int unsigned CORDIC_STAGES = 32
) (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid,
   input wire [hav_pkg::DistW-1:0] rsp_distance_cm
);
   import hav_pkg::*;
   localparam int unsigned Lat = 2 * CORDIC_STAGES + 26;

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Lat))
      else $error("result without a request");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_distance_cm))
      else $error("unknown distance");
endmodule

bind haversine_distance haversine_distance_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_distance_cm(rsp_distance_cm));
`default_nettype wire
